// ===== design/dinf_pkg.sv =====
// ----------------------------------------------------------------------------
// dinf_pkg
// Widths, word types and constant tables shared by the flow direction block.
// ----------------------------------------------------------------------------
package dinf_pkg;

  localparam int ELEV_BITS    = 16;
  localparam int ANGLE_BITS   = 16;
  localparam int SLOPE_FRAC   = 8;
  localparam int NUM_FACETS   = 8;
  localparam int FACET_BITS   = 3;

  localparam int DIFF_BITS    = ELEV_BITS + 1;
  localparam int MAG_BITS     = ELEV_BITS;
  localparam int SQ_BITS      = 2 * MAG_BITS;
  localparam int ROOT_BITS    = (SQ_BITS + 1 + 2 * SLOPE_FRAC + 1) / 2;
  localparam int OPND_BITS    = 2 * ROOT_BITS;
  localparam int REM_BITS     = ROOT_BITS + 3;
  localparam int SLOPE_BITS   = ROOT_BITS + 1;

  localparam int CORDIC_STEPS = 26;
  localparam int NORM_MSB     = 39;
  localparam int SH_BITS      = $clog2(NORM_MSB + 1);
  localparam int MSB_BITS     = $clog2(MAG_BITS);
  localparam int CX_BITS      = NORM_MSB + 4;
  localparam int Z_BITS       = 34;
  localparam int ZC_BITS      = 30;

  localparam int LANE_ANG_BITS = ANGLE_BITS - 2;
  localparam int OUT_ANG_BITS  = ANGLE_BITS + 1;
  localparam logic [LANE_ANG_BITS-1:0] EIGHTH = LANE_ANG_BITS'(1) << (ANGLE_BITS - 3);

  localparam int ITER_STEPS   = (ROOT_BITS > CORDIC_STEPS) ? ROOT_BITS : CORDIC_STEPS;
  localparam int LANE_STAGES  = ITER_STEPS + 4;
  localparam int MERGE_STAGES = 3;
  localparam int PIPE_STAGES  = LANE_STAGES + MERGE_STAGES;

  typedef logic signed [ELEV_BITS-1:0] elev_t;

  typedef struct packed {
    elev_t center_elev;
    elev_t north_elev;
    elev_t northeast_elev;
    elev_t east_elev;
    elev_t southeast_elev;
    elev_t south_elev;
    elev_t southwest_elev;
    elev_t west_elev;
    elev_t northwest_elev;
  } src_word_t;

  typedef struct packed {
    logic [OUT_ANG_BITS-1:0] flow_angle;
    logic                    no_flow;
    logic [FACET_BITS-1:0]   winning_facet;
  } res_word_t;

  typedef struct packed {
    logic signed [SLOPE_BITS-1:0] slope;
    logic [LANE_ANG_BITS-1:0]     angle;
  } lane_res_t;

  // arctangent of 2^-i in units of 2*pi/2^32
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h20000000;  1:  v = 32'h12E4051E;  2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;  4:  v = 32'h028B0D43;  5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;  7:  v = 32'h00517C55;  8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;  10: v = 32'h000A2F98;  11: v = 32'h000517CC;
      12: v = 32'h00028BE6;  13: v = 32'h000145F3;  14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;  16: v = 32'h000028BE;  17: v = 32'h0000145F;
      18: v = 32'h00000A30;  19: v = 32'h00000518;  20: v = 32'h0000028C;
      21: v = 32'h00000146;  22: v = 32'h000000A3;  23: v = 32'h00000051;
      24: v = 32'h00000029;  25: v = 32'h00000014;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  // quarter-turn count at the base of each facet
  function automatic logic [2:0] quad_of(input logic [FACET_BITS-1:0] k);
    logic [2:0] q;
    case (k)
      3'd0:           q = 3'd0;
      3'd1, 3'd2:     q = 3'd1;
      3'd3, 3'd4:     q = 3'd2;
      3'd5, 3'd6:     q = 3'd3;
      default:        q = 3'd4;
    endcase
    return q;
  endfunction

endpackage

// ===== design/dinf_lane.sv =====
// ----------------------------------------------------------------------------
// dinf_lane
// One facet: slope by pipelined square root, in-facet angle by pipelined
// vectoring rotation, both one step per stage.
// ----------------------------------------------------------------------------
module dinf_lane (
  input  logic                                 clk,
  input  logic [dinf_pkg::LANE_STAGES-1:0]     en,
  input  dinf_pkg::elev_t                      c,
  input  dinf_pkg::elev_t                      a,
  input  dinf_pkg::elev_t                      b,
  output dinf_pkg::lane_res_t                  res
);
  import dinf_pkg::*;

  typedef struct packed {
    logic                        neg2;
    logic                        gt;
    logic                        dneg;
    logic                        zero;
    logic                        eq;
    logic signed [DIFF_BITS-1:0] s1;
  } ctl_t;

  // stage 1: differences
  logic signed [DIFF_BITS-1:0] s1, s2, d;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1 <= $signed({c[ELEV_BITS-1], c}) - $signed({a[ELEV_BITS-1], a});
      s2 <= $signed({a[ELEV_BITS-1], a}) - $signed({b[ELEV_BITS-1], b});
      d  <= $signed({c[ELEV_BITS-1], c}) - $signed({b[ELEV_BITS-1], b});
    end
  end

  // stage 2: squares and normalisation
  logic                        neg2_c, gt_c, diag_c;
  logic signed [DIFF_BITS-1:0] d_abs;
  logic [MAG_BITS-1:0]         s1_mag, s2_mag, mb;
  logic [MSB_BITS-1:0]         msb;
  logic [SH_BITS-1:0]          sh;

  always_comb begin
    neg2_c = s2[DIFF_BITS-1];
    gt_c   = !neg2_c && (s2 > s1);
    diag_c = neg2_c || gt_c;
    d_abs  = d[DIFF_BITS-1] ? -d : d;
    s1_mag = s1[MAG_BITS-1:0];
    s2_mag = s2[MAG_BITS-1:0];
    mb     = diag_c ? d_abs[MAG_BITS-1:0] : s2_mag;
    msb    = '0;
    for (int j = 0; j < MAG_BITS; j++) begin
      if (s1_mag[j]) msb = MSB_BITS'(j);
    end
    sh = SH_BITS'(NORM_MSB) - SH_BITS'(msb);
  end

  logic [SQ_BITS-1:0]         sq_a, sq_b;
  logic                       diag2;
  ctl_t                       ctl2;
  logic signed [CX_BITS-1:0]  x2, y2;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sq_a  <= diag_c ? '0 : s1_mag * s1_mag;
      sq_b  <= mb * mb;
      diag2 <= diag_c;
      ctl2  <= '{neg2: neg2_c, gt: gt_c, dneg: d[DIFF_BITS-1], zero: (s2 == '0),
                 eq: (s2 == s1), s1: s1};
      x2    <= $signed(CX_BITS'(s1_mag) << sh);
      y2    <= $signed(CX_BITS'(s2_mag) << sh);
    end
  end

  // stage 3 onwards: iteration registers, index 0 is the start value
  logic [OPND_BITS-1:0]       opnd_it [ITER_STEPS+1];
  logic [REM_BITS-1:0]        rem_it  [ITER_STEPS+1];
  logic [ROOT_BITS-1:0]       root_it [ITER_STEPS+1];
  logic signed [CX_BITS-1:0]  x_it    [ITER_STEPS+1];
  logic signed [CX_BITS-1:0]  y_it    [ITER_STEPS+1];
  logic signed [Z_BITS-1:0]   z_it    [ITER_STEPS+1];
  ctl_t                       ctl_it  [ITER_STEPS+1];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      opnd_it[0] <= diag2 ? (OPND_BITS'(sq_b) << (2 * SLOPE_FRAC - 1))
                          : ((OPND_BITS'(sq_a) + OPND_BITS'(sq_b)) << (2 * SLOPE_FRAC));
      rem_it[0]  <= '0;
      root_it[0] <= '0;
      x_it[0]    <= x2;
      y_it[0]    <= y2;
      z_it[0]    <= '0;
      ctl_it[0]  <= ctl2;
    end
  end

  for (genvar i = 0; i < ITER_STEPS; i++) begin : g_iter
    logic [REM_BITS-1:0] rem_sh, trial;
    logic                fits;

    always_comb begin
      rem_sh = {rem_it[i][REM_BITS-3:0], opnd_it[i][OPND_BITS-1 -: 2]};
      trial  = REM_BITS'({root_it[i], 2'b01});
      fits   = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (en[3+i]) begin
        ctl_it[i+1]  <= ctl_it[i];
        opnd_it[i+1] <= opnd_it[i] << 2;
        if (i < ROOT_BITS) begin
          rem_it[i+1]  <= fits ? rem_sh - trial : rem_sh;
          root_it[i+1] <= {root_it[i][ROOT_BITS-2:0], fits};
        end else begin
          rem_it[i+1]  <= rem_it[i];
          root_it[i+1] <= root_it[i];
        end
        if (i < CORDIC_STEPS) begin
          if (!y_it[i][CX_BITS-1]) begin
            x_it[i+1] <= x_it[i] + (y_it[i] >>> i);
            y_it[i+1] <= y_it[i] - (x_it[i] >>> i);
            z_it[i+1] <= z_it[i] + $signed(Z_BITS'(atan_turn(i)));
          end else begin
            x_it[i+1] <= x_it[i] - (y_it[i] >>> i);
            y_it[i+1] <= y_it[i] + (x_it[i] >>> i);
            z_it[i+1] <= z_it[i] - $signed(Z_BITS'(atan_turn(i)));
          end
        end else begin
          x_it[i+1] <= x_it[i];
          y_it[i+1] <= y_it[i];
          z_it[i+1] <= z_it[i];
        end
      end
    end
  end

  // final stage: pick slope and angle for the facet
  ctl_t                         cf;
  logic signed [SLOPE_BITS-1:0] root_s, dsl, t1, slope_c;
  logic signed [Z_BITS-1:0]     zf;
  logic [ZC_BITS-1:0]           zc;
  logic [ZC_BITS:0]             zr;
  logic [LANE_ANG_BITS-1:0]     cang, ang_c;

  always_comb begin
    cf     = ctl_it[ITER_STEPS];
    root_s = $signed(SLOPE_BITS'(root_it[ITER_STEPS]));
    dsl    = cf.dneg ? -(root_s + SLOPE_BITS'(1)) : root_s;
    t1     = SLOPE_BITS'(cf.s1) <<< SLOPE_FRAC;
    zf     = z_it[ITER_STEPS];
    // clamp to the first eighth of a turn
    if (zf[Z_BITS-1]) begin
      zc = '0;
    end else if (zf > $signed(Z_BITS'(1) <<< 29)) begin
      zc = ZC_BITS'(1) << 29;
    end else begin
      zc = zf[ZC_BITS-1:0];
    end
    zr   = {1'b0, zc} + ((ZC_BITS+1)'(1) << (31 - ANGLE_BITS));
    cang = zr[32-ANGLE_BITS +: LANE_ANG_BITS];
    if (cf.neg2) begin
      if (dsl > t1) begin
        slope_c = dsl;
        ang_c   = EIGHTH;
      end else begin
        slope_c = t1;
        ang_c   = '0;
      end
    end else if (cf.gt) begin
      slope_c = dsl;
      ang_c   = EIGHTH;
    end else begin
      slope_c = root_s;
      ang_c   = cf.zero ? '0 : (cf.eq ? EIGHTH : cang);
    end
  end

  always_ff @(posedge clk) begin
    if (en[3+ITER_STEPS]) begin
      res <= '{slope: slope_c, angle: ang_c};
    end
  end

endmodule

// ===== design/dinf_merge.sv =====
// ----------------------------------------------------------------------------
// dinf_merge
// Registered three-level tree that keeps the first steepest facet, then forms
// the global flow angle.
// ----------------------------------------------------------------------------
module dinf_merge (
  input  logic                                  clk,
  input  logic [dinf_pkg::MERGE_STAGES-1:0]     en,
  input  dinf_pkg::lane_res_t                   lane [dinf_pkg::NUM_FACETS],
  output dinf_pkg::res_word_t                   word
);
  import dinf_pkg::*;

  lane_res_t             l1 [4];
  logic [FACET_BITS-1:0] i1 [4];
  lane_res_t             l2 [2];
  logic [FACET_BITS-1:0] i2 [2];

  // ties keep the lower facet
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int j = 0; j < 4; j++) begin
        if (lane[2*j+1].slope > lane[2*j].slope) begin
          l1[j] <= lane[2*j+1];
          i1[j] <= FACET_BITS'(2*j+1);
        end else begin
          l1[j] <= lane[2*j];
          i1[j] <= FACET_BITS'(2*j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int j = 0; j < 2; j++) begin
        if (l1[2*j+1].slope > l1[2*j].slope) begin
          l2[j] <= l1[2*j+1];
          i2[j] <= i1[2*j+1];
        end else begin
          l2[j] <= l1[2*j];
          i2[j] <= i1[2*j];
        end
      end
    end
  end

  lane_res_t               win;
  logic [FACET_BITS-1:0]   win_idx;
  logic [OUT_ANG_BITS-1:0] base, ang;

  always_comb begin
    if (l2[1].slope > l2[0].slope) begin
      win     = l2[1];
      win_idx = i2[1];
    end else begin
      win     = l2[0];
      win_idx = i2[0];
    end
    base = OUT_ANG_BITS'(quad_of(win_idx)) << (ANGLE_BITS - 2);
    ang  = win_idx[0] ? base - OUT_ANG_BITS'(win.angle) : base + OUT_ANG_BITS'(win.angle);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      word.no_flow       <= win.slope[SLOPE_BITS-1];
      word.flow_angle    <= win.slope[SLOPE_BITS-1] ? '0 : ang;
      word.winning_facet <= win_idx;
    end
  end

endmodule

// ===== design/dinf_flow_direction.sv =====
// ----------------------------------------------------------------------------
// dinf_flow_direction
// D-infinity flow direction of the centre pixel of a 3x3 elevation window.
// ----------------------------------------------------------------------------
// Usage:
//   src_* carries one window a word (valid/stall); res_* returns one word a
//   window: flow angle in 2*pi/65536 units, no-flow flag and winning facet.
//   Eight facet lanes run side by side; each takes a square root one bit a
//   stage and the angle rotation one step a stage, so the lane is 30 stages
//   deep, then a three-stage compare tree picks the steepest facet.
//   One window is taken every cycle unless a stall on res_* has backed up
//   every stage; the rate is then one word per clock.
//   Each stage has its own valid bit and loads when empty or when the stage
//   after it moves on, so bubbles close up. A stall on res_* holds the output
//   word; earlier stages keep filling and src_stall rises only when every
//   stage holds a word.
//   Reset (rst, synchronous) empties the pipeline; there is no other state.
// ----------------------------------------------------------------------------
module dinf_flow_direction (
  input  logic                clk,
  input  logic                rst,
  input  logic                src_valid,
  output logic                src_stall,
  input  dinf_pkg::src_word_t src_data,
  output logic                res_valid,
  input  logic                res_stall,
  output dinf_pkg::res_word_t res_data
);
  import dinf_pkg::*;

  logic [PIPE_STAGES-1:0] vld;
  logic [PIPE_STAGES:0]   en;

  always_comb begin
    en[PIPE_STAGES] = !res_stall;
    for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= src_valid;
      for (int k = 1; k < PIPE_STAGES; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign src_stall = !en[0];
  assign res_valid = vld[PIPE_STAGES-1];

  elev_t side [NUM_FACETS];
  elev_t diag [NUM_FACETS];

  assign side[0] = src_data.east_elev;   assign diag[0] = src_data.northeast_elev;
  assign side[1] = src_data.north_elev;  assign diag[1] = src_data.northeast_elev;
  assign side[2] = src_data.north_elev;  assign diag[2] = src_data.northwest_elev;
  assign side[3] = src_data.west_elev;   assign diag[3] = src_data.northwest_elev;
  assign side[4] = src_data.west_elev;   assign diag[4] = src_data.southwest_elev;
  assign side[5] = src_data.south_elev;  assign diag[5] = src_data.southwest_elev;
  assign side[6] = src_data.south_elev;  assign diag[6] = src_data.southeast_elev;
  assign side[7] = src_data.east_elev;   assign diag[7] = src_data.southeast_elev;

  lane_res_t lane_res [NUM_FACETS];

  for (genvar k = 0; k < NUM_FACETS; k++) begin : g_lane
    dinf_lane u_lane (
      .clk (clk),
      .en  (en[LANE_STAGES-1:0]),
      .c   (src_data.center_elev),
      .a   (side[k]),
      .b   (diag[k]),
      .res (lane_res[k])
    );
  end

  dinf_merge u_merge (
    .clk  (clk),
    .en   (en[PIPE_STAGES-1:LANE_STAGES]),
    .lane (lane_res),
    .word (res_data)
  );

endmodule

// ===== design/dinf_checker.sv =====
// ----------------------------------------------------------------------------
// dinf_checker
// Port-level checks on the flow direction block, bound to the top level.
// ----------------------------------------------------------------------------
module dinf_checker (
  input logic                clk,
  input logic                rst,
  input logic                src_valid,
  input logic                src_stall,
  input dinf_pkg::src_word_t src_data,
  input logic                res_valid,
  input logic                res_stall,
  input dinf_pkg::res_word_t res_data
);
  import dinf_pkg::*;

  a_src_hold: assert property (@(posedge clk) disable iff (rst)
    src_valid && src_stall |=> src_valid && $stable(src_data))
    else $error("stalled source word changed");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("stalled result word changed");

  a_noflow: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.no_flow |-> res_data.flow_angle == '0)
    else $error("no-flow word carries an angle");

  a_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_data.flow_angle <= (OUT_ANG_BITS'(1) << ANGLE_BITS))
    else $error("flow angle beyond a full turn");

  a_reset: assert property (@(posedge clk)
    rst |=> !res_valid && !src_stall)
    else $error("pipeline not empty after reset");

endmodule

bind dinf_flow_direction dinf_checker u_dinf_checker (.*);

// ===== tb/sv/dinf_flow_direction_tb.sv =====
// ----------------------------------------------------------------------------
// dinf_flow_direction_tb
// Self-checking bench for the D-infinity flow direction block. A short table
// of hand-picked windows is followed by random terrain and noise windows.
// Every result word is checked against a bit-exact predictor of the facet
// slopes, the angle rotation and the steepest-facet choice. Both handshakes
// idle at random, in phases.
// ----------------------------------------------------------------------------
module dinf_flow_direction_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dinf_pkg::*;

  localparam int N_RANDOM  = 830;
  localparam int DRAIN_CYC = 60;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      src_valid = 1'b0;
  logic      src_stall;
  src_word_t src_data = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  res_word_t res_data;

  int unsigned src_idle_pct = 0;
  int unsigned res_stall_pct = 0;
  int unsigned n_errors = 0;
  int unsigned n_checked = 0;
  int unsigned n_no_flow = 0;
  res_word_t   flow_due[$];

  typedef struct {
    src_word_t w;
    bit        typed;
    res_word_t want;
  } window_row_t;

  dinf_flow_direction dut (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_stall(src_stall), .src_data(src_data),
    .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  localparam logic [31:0] ATAN_STEP [26] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014};
  localparam int SIDE_IDX [8] = '{3, 1, 1, 7, 7, 5, 5, 3};
  localparam int DIAG_IDX [8] = '{2, 2, 8, 8, 6, 6, 4, 4};
  localparam int QUAD_IDX [8] = '{0, 1, 1, 2, 2, 3, 3, 4};

  function automatic longint root_floor(logic [127:0] t);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int b = 47; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= t) r = c;
    end
    return longint'(r[63:0]);
  endfunction

  // floor(256*d/sqrt2)
  function automatic longint diag_drop(longint d);
    logic [127:0] a;
    longint r;
    a = (d < 0) ? -d : d;
    r = root_floor((a * a) << 15);
    return (d < 0) ? -(r + 1) : r;
  endfunction

  function automatic longint facet_turn(longint s1, longint s2);
    longint x, y, z;
    if (s2 == 0) return 0;
    if (s2 == s1) return longint'(1) << (ANGLE_BITS - 3);
    x = s1;
    y = s2;
    while (x < (longint'(1) << 39)) begin
      x = x <<< 1;
      y = y <<< 1;
    end
    z = 0;
    for (int i = 0; i < 26; i++) begin
      longint dx, dy;
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(ATAN_STEP[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(ATAN_STEP[i]);
      end
    end
    if (z < 0) z = 0;
    if (z > (longint'(1) << 29)) z = longint'(1) << 29;
    return (z + (longint'(1) << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS);
  endfunction

  function automatic res_word_t predict_flow(src_word_t w);
    longint e [9];
    longint best_slope, best_ang, c, a, b, s1, s2, slope, ang, t1, t2, base;
    int best;
    res_word_t r;
    e = '{w.center_elev, w.north_elev, w.northeast_elev, w.east_elev,
          w.southeast_elev, w.south_elev, w.southwest_elev, w.west_elev,
          w.northwest_elev};
    best_slope = 0;
    best_ang = 0;
    best = 0;
    for (int k = 0; k < 8; k++) begin
      c = e[0];
      a = e[SIDE_IDX[k]];
      b = e[DIAG_IDX[k]];
      s1 = c - a;
      s2 = a - b;
      if (s2 < 0) begin
        t1 = s1 * 256;
        t2 = diag_drop(c - b);
        if (t2 > t1) begin
          ang = longint'(1) << (ANGLE_BITS - 3); slope = t2;
        end else begin
          ang = 0; slope = t1;
        end
      end else if (s2 > s1) begin
        ang = longint'(1) << (ANGLE_BITS - 3);
        slope = diag_drop(c - b);
      end else begin
        logic [127:0] sq;
        sq = (128'(s1) * 128'(s1) + 128'(s2) * 128'(s2)) << 16;
        ang = facet_turn(s1, s2);
        slope = root_floor(sq);
      end
      if (k == 0 || slope > best_slope) begin
        best_slope = slope;
        best_ang = ang;
        best = k;
      end
    end
    if (best_slope >= 0) begin
      base = longint'(QUAD_IDX[best]) << (ANGLE_BITS - 2);
      r.flow_angle = (best % 2) ? OUT_ANG_BITS'(base - best_ang)
                                : OUT_ANG_BITS'(base + best_ang);
      r.no_flow = 1'b0;
    end else begin
      r.flow_angle = '0;
      r.no_flow = 1'b1;
    end
    r.winning_facet = FACET_BITS'(best);
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic src_word_t window_of(int cv, int n, int ne, int ea, int se,
                                          int s, int sw, int we, int nw);
    src_word_t w;
    w = {elev_t'(cv), elev_t'(n), elev_t'(ne), elev_t'(ea), elev_t'(se),
         elev_t'(s), elev_t'(sw), elev_t'(we), elev_t'(nw)};
    return w;
  endfunction

  function automatic src_word_t random_window();
    src_word_t w;
    logic [159:0] raw;
    int base, spread;
    case ($urandom_range(3))
      0: begin
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        w = raw[$bits(src_word_t)-1:0];
      end
      default: begin
        // terrain-like: small spread around a base, frequent ties
        spread = (1 << $urandom_range(12));
        base = $urandom_range(65535) - 32768;
        if (base > 32767 - spread) base = 32767 - spread;
        if (base < -32768 + spread) base = -32768 + spread;
        w = window_of(base + $urandom_range(2 * spread) - spread,
                      base + $urandom_range(2 * spread) - spread,
                      base + $urandom_range(2 * spread) - spread,
                      base + $urandom_range(2 * spread) - spread,
                      base + $urandom_range(2 * spread) - spread,
                      base + $urandom_range(2 * spread) - spread,
                      base + $urandom_range(2 * spread) - spread,
                      base + $urandom_range(2 * spread) - spread,
                      base + $urandom_range(2 * spread) - spread);
      end
    endcase
    return w;
  endfunction

  task automatic send_window(src_word_t w, bit typed, res_word_t want);
    while ($urandom_range(99) < src_idle_pct) begin
      src_valid <= 1'b0;
      @(posedge clk);
    end
    src_valid <= 1'b1;
    src_data  <= w;
    do @(posedge clk); while (src_stall);
    flow_due.push_back(typed ? want : predict_flow(w));
  endtask

  task automatic set_phase(int unsigned idx);
    case (idx % 4)
      0: begin src_idle_pct = 0;  res_stall_pct = 0;  end
      1: begin src_idle_pct = 46; res_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  res_stall_pct = 46; end
      default: begin src_idle_pct = 27; res_stall_pct = 27; end
    endcase
  endtask

  always @(posedge clk) res_stall <= ($urandom_range(99) < res_stall_pct);

  // ---------------------------------------------------------------- checking
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (flow_due.size() == 0) begin
        $error("result word with nothing expected: %h", res_data);
        n_errors++;
      end else begin
        res_word_t want;
        want = flow_due.pop_front();
        n_checked++;
        if (res_data.no_flow) n_no_flow++;
        if (res_data.flow_angle !== want.flow_angle) begin
          $error("flow_angle: expected %0d, got %0d", want.flow_angle,
                 res_data.flow_angle);
          n_errors++;
        end
        if (res_data.no_flow !== want.no_flow) begin
          $error("no_flow: expected %0d, got %0d", want.no_flow, res_data.no_flow);
          n_errors++;
        end
        if (res_data.winning_facet !== want.winning_facet) begin
          $error("winning_facet: expected %0d, got %0d", want.winning_facet,
                 res_data.winning_facet);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("timeout with %0d words outstanding", flow_due.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    window_row_t rows [$];
    rows.push_back('{window_of(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, '{0, 0, 0}});
    rows.push_back('{window_of(-32768, 32767, 32767, 32767, 32767, 32767, 32767,
                               32767, 32767), 1, '{0, 1, 0}});
    rows.push_back('{window_of(32767, -32768, -32768, -32768, -32768, -32768,
                               -32768, -32768, -32768), 1, '{0, 0, 0}});
    rows.push_back('{window_of(5, 5, 5, 5, 5, 5, 5, 5, 5), 1, '{0, 0, 0}});
    // one low neighbour in each direction
    for (int d = 1; d <= 8; d++) begin
      int v [9];
      v = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
      v[d] = -100;
      rows.push_back('{window_of(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7],
                                 v[8]), 0, '{0, 0, 0}});
    end
    // equal drops east and south-east: the lower facet keeps the tie
    rows.push_back('{window_of(0, 0, 0, -100, -100, 0, 0, 0, 0), 0, '{0, 0, 0}});
    // side and diagonal equal drop (angle exactly one eighth)
    rows.push_back('{window_of(0, 0, -200, -100, 0, 0, 0, 0, 0), 0, '{0, 0, 0}});
    // diagonal steeper than the side, side drop negative
    rows.push_back('{window_of(0, 0, -300, 50, 0, 0, 0, 0, 0), 0, '{0, 0, 0}});
    // CORDIC angle in the open interval
    rows.push_back('{window_of(1000, 900, 900, 700, 650, 990, 995, 998, 999), 0,
                     '{0, 0, 0}});
    rows.push_back('{window_of(-32768, -32768, 32767, -32768, 32767, -32768, 32767,
                               -32768, 32767), 0, '{0, 0, 0}});
    rows.push_back('{window_of(32767, 32767, -32768, 32767, -32768, 32767, -32768,
                               32767, -32768), 0, '{0, 0, 0}});
    rows.push_back('{window_of(1, 0, -1, 1, 2, 0, 0, 1, 1), 0, '{0, 0, 0}});

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_window(rows[i].w, rows[i].typed, rows[i].want);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 100 == 0) set_phase(i / 100);
      send_window(random_window(), 0, '{0, 0, 0});
    end
    src_valid <= 1'b0;

    while (flow_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("checked %0d result words (%0d flagged no flow) across %0d table rows",
             n_checked, n_no_flow, rows.size());
    $display("and %0d random windows under four idling patterns", N_RANDOM);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
